// ----- rtl/kmer_presence_sketch_defines.svh -----
// Assertion macros for the k-mer presence sketch.
`ifndef KMER_PRESENCE_SKETCH_DEFINES_SVH
`define KMER_PRESENCE_SKETCH_DEFINES_SVH

`ifndef SYNTHESIS
`define KPS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kps assertion failed");
`define KPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kps assertion failed");
`else
`define KPS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define KPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/kps_pkg.sv -----
package kps_pkg;

  localparam int KMER_MAX_DEF = 10;
  localparam int KMER_MIN = 4;
  localparam logic [3:0] KMER_LEN_RESET = 4'd8;
  localparam int COUNT_W = 21;
  localparam int WORD_W = 64;
  localparam int BIT_IDX_W = 6;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register index taken from paddr[2]
  localparam logic REG_KMER_LEN = 1'b0;

  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;
  localparam logic [2:0] BASE_INVALID = 3'd7;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_DRAIN
  } kps_state_t;

  typedef struct packed {
    logic kvalid;
    logic last;
  } kps_tag_t;

  // low five bits of the letter, case-blind
  function automatic logic [2:0] base_map(input logic [4:0] ch);
    logic [2:0] code;
    case (ch)
      5'd1: code = BASE_A;
      5'd3: code = BASE_C;
      5'd7: code = BASE_G;
      5'd20, 5'd21: code = BASE_T;
      default: code = BASE_INVALID;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/kps_window.sv -----
module kps_window #(
  parameter int KMER_MAX = kps_pkg::KMER_MAX_DEF,
  localparam int W = 2 * KMER_MAX,
  localparam int RW = $clog2(KMER_MAX + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       base_char,
  input  logic             last_base,
  input  logic [RW-1:0]    k_eff,
  output logic [W-1:0]     code,
  output kps_pkg::kps_tag_t tag
);

  logic [W-1:0]  window;
  logic [W-1:0]  window_next;
  logic [RW-1:0] run;
  logic [RW-1:0] run_next;
  logic [2:0]    x;
  logic [RW:0]   shamt;

  assign x = kps_pkg::base_map(base_char[4:0]);
  assign shamt = {RW'(KMER_MAX) - k_eff, 1'b0};

  always_comb begin
    window_next = window;
    run_next = '0;
    tag.kvalid = 1'b0;
    tag.last = last_base;
    code = '0;
    if (x != kps_pkg::BASE_INVALID) begin
      window_next = {x[1:0], window[W-1:2]};
      run_next = (run >= k_eff) ? k_eff : run + RW'(1);
      tag.kvalid = (run_next == k_eff);
      // top K bases of the window, oldest in the low bits
      if (tag.kvalid) begin
        code = window_next >> shamt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      run <= '0;
    end else if (advance) begin
      if (last_base) begin
        window <= '0;
        run <= '0;
      end else begin
        window <= window_next;
        run <= run_next;
      end
    end
  end

endmodule

// ----- rtl/kps_mem.sv -----
module kps_mem #(
  parameter int AW = 14,
  parameter int DW = kps_pkg::WORD_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/kmer_presence_sketch.sv -----
// A result is registered in the s1 stage, then in the output register. One base
// per cycle within a sequence while the output does not stall; the bitmap
// read-modify-write forwards the word written in the same cycle as a read of it.
// After reset the input stalls for one clearing pass over 2^(2*KMER_MAX-6) words
// (16384 at KMER_MAX=10), one word a cycle, and after each last base while the final
// base drains (longer if the output stalls) and then clears. kmer_len resets to 8.
`include "kmer_presence_sketch_defines.svh"

module kmer_presence_sketch #(
  parameter int KMER_MAX = kps_pkg::KMER_MAX_DEF,
  localparam int W = 2 * KMER_MAX,
  localparam int RW = $clog2(KMER_MAX + 1),
  localparam int CW = (RW > 4) ? RW : 4,
  localparam int AW = W - kps_pkg::BIT_IDX_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kps_pkg::PADDR_W-1:0] paddr,
  input  logic [kps_pkg::PDATA_W-1:0] pwdata,
  output logic [kps_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  base_char,
  input  logic                        last_base,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        kmer_valid,
  output logic [W-1:0]                kmer_code,
  output logic                        first_seen,
  output logic [kps_pkg::COUNT_W-1:0] distinct_count,
  output logic                        seq_end
);

  logic [3:0]    kmer_len;
  logic [CW-1:0] klen_ext;
  logic [RW-1:0] k_eff;

  kps_pkg::kps_state_t state;
  kps_pkg::kps_state_t state_next;
  logic [AW-1:0] clr_addr;
  logic          clearing;
  logic          in_accept;

  logic [W-1:0]      front_code;
  kps_pkg::kps_tag_t front_tag;

  logic                          s1_valid;
  logic                          s1_kvalid;
  logic                          s1_last;
  logic [W-1:0]                  s1_code;
  logic                          s1_fwd;
  logic [kps_pkg::WORD_W-1:0]    s1_fwd_data;
  logic                          s1_go;
  logic                          s1_fire;
  logic                          s1_write;
  logic [kps_pkg::WORD_W-1:0]    word;
  logic [kps_pkg::WORD_W-1:0]    word_set;
  logic                          first;
  logic [kps_pkg::COUNT_W-1:0]   count;
  logic [kps_pkg::COUNT_W-1:0]   count_next;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [kps_pkg::WORD_W-1:0]    mem_wdata;
  logic [kps_pkg::WORD_W-1:0]    mem_rdata;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == kps_pkg::REG_KMER_LEN) ?
                  {{(kps_pkg::PDATA_W-4){1'b0}}, kmer_len} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len <= kps_pkg::KMER_LEN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == kps_pkg::REG_KMER_LEN) begin
      kmer_len <= pwdata[3:0];
    end
  end

  assign klen_ext = CW'(kmer_len);
  always_comb begin
    if (klen_ext < CW'(kps_pkg::KMER_MIN)) begin
      k_eff = RW'(kps_pkg::KMER_MIN);
    end else if (klen_ext > CW'(KMER_MAX)) begin
      k_eff = RW'(KMER_MAX);
    end else begin
      k_eff = RW'(klen_ext);
    end
  end

  // sequencing: clear sweep, run, drain after the last base
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kps_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    clearing = 1'b0;
    in_stall = 1'b1;
    case (state)
      kps_pkg::ST_CLEAR: begin
        clearing = 1'b1;
        if (clr_addr == '1) begin
          state_next = kps_pkg::ST_RUN;
        end
      end
      kps_pkg::ST_RUN: begin
        in_stall = s1_valid && !s1_go;
        if (in_valid && !in_stall && last_base) begin
          state_next = kps_pkg::ST_DRAIN;
        end
      end
      kps_pkg::ST_DRAIN: begin
        if (!s1_valid) begin
          state_next = kps_pkg::ST_CLEAR;
        end
      end
      default: state_next = kps_pkg::ST_CLEAR;
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  kps_window #(
    .KMER_MAX(KMER_MAX)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .advance  (in_accept),
    .base_char(base_char),
    .last_base(last_base),
    .k_eff    (k_eff),
    .code     (front_code),
    .tag      (front_tag)
  );

  // test and set the k-mer bit
  assign word = s1_fwd ? s1_fwd_data : mem_rdata;
  assign first = s1_kvalid && !word[s1_code[kps_pkg::BIT_IDX_W-1:0]];
  assign word_set = word |
                    (kps_pkg::WORD_W'(1) << s1_code[kps_pkg::BIT_IDX_W-1:0]);
  assign s1_go = !out_valid || !out_stall;
  assign s1_fire = s1_valid && s1_go;
  assign s1_write = s1_fire && first;
  assign count_next = (first && count != '1) ? count + kps_pkg::COUNT_W'(1) : count;

  assign mem_we = clearing || s1_write;
  assign mem_waddr = clearing ? clr_addr : s1_code[W-1:kps_pkg::BIT_IDX_W];
  assign mem_wdata = clearing ? '0 : word_set;

  kps_mem #(
    .AW(AW),
    .DW(kps_pkg::WORD_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (in_accept && front_tag.kvalid),
    .raddr(front_code[W-1:kps_pkg::BIT_IDX_W]),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kvalid <= front_tag.kvalid;
      s1_last <= front_tag.last;
      s1_code <= front_code;
      // the read misses a write to the same word at this edge: forward it
      s1_fwd <= s1_write && front_tag.kvalid &&
                (s1_code[W-1:kps_pkg::BIT_IDX_W] == front_code[W-1:kps_pkg::BIT_IDX_W]);
      s1_fwd_data <= word_set;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (s1_fire) begin
      count <= s1_last ? '0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      kmer_valid <= s1_kvalid;
      kmer_code <= s1_code;
      first_seen <= first;
      distinct_count <= count_next;
      seq_end <= s1_last;
    end
  end

  `KPS_ASSERT_IMPLIES(a_clear_idle, clk, rst, state == kps_pkg::ST_CLEAR, !s1_valid && in_stall)
  `KPS_ASSERT_IMPLIES(a_first_has_kmer, clk, rst, out_valid, !first_seen || kmer_valid)
  `KPS_ASSERT_NEXT(a_count_cleared, clk, rst, s1_fire && s1_last, count == '0)
  `KPS_ASSERT_IMPLIES(a_fwd_has_kmer, clk, rst, s1_valid && s1_fwd, s1_kvalid)

endmodule
